>>> hdl/grid_obstacle_distance_transform_assert.svh
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef GRID_OBSTACLE_DISTANCE_TRANSFORM_ASSERT_SVH
`define GRID_OBSTACLE_DISTANCE_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define GDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gdt_pkg.sv
package gdt_pkg;

  localparam int DIST_W = 17;
  localparam int WORD_W = DIST_W + 1;

  localparam logic [DIST_W-1:0] DIST_FAR   = '1;
  localparam logic [DIST_W:0]   COST_ORTHO = 18'd256;
  localparam logic [DIST_W:0]   COST_DIAG  = 18'd362;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SEED  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_NOT_DONE = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  // kind of word coming back from the cell store during a sweep
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_SELF = 2'd1;
  localparam logic [1:0] K_ORTH = 2'd2;
  localparam logic [1:0] K_DIAG = 2'd3;

  typedef struct packed {
    logic busy;
    logic wr;
    logic done;
  } disk_ctl_t;

endpackage

>>> hdl/grid_obstacle_distance_transform.sv
// channel | ports                                        | accepted when
// --------+----------------------------------------------+----------------------------
// input   | in_operation, in_cell_x, in_cell_y           | in_valid && in_ready
// result  | out_status, out_distance                     | out_valid && out_ready
// config  | psel, penable, pwrite, paddr, pwdata, prdata | psel && penable && pwrite
//
// a mark walks a (2k+1)^2 window with k the window half size, a clear walks the whole
//   store, and a compute runs passes until nothing drops, where
//   one pass is a forward and a backward raster sweep, repeated until nothing drops
// the single read port of the cell store sets the pace: each sweep cell issues five
//   reads (itself and four neighbors), one per cycle, then writes back
// after reset the whole store is swept clear with
//   in_ready low; config writes are taken throughout
// one item at a time; the result register lets the next item in once loaded
`include "grid_obstacle_distance_transform_assert.svh"

module grid_obstacle_distance_transform #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_cell_x,
  input  logic [7:0]  in_cell_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [16:0] out_distance,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int UW = $clog2(MAX_WIDTH + 1);
  localparam int VW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = gdt_pkg::DIST_W;
  localparam int WW = gdt_pkg::WORD_W;

  localparam logic [2:0] LAST_STEP = 3'd5;

  // sequencer states
  localparam logic [2:0] S_CLR     = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_MARK    = 3'd2;
  localparam logic [2:0] S_INIT_RD = 3'd3;
  localparam logic [2:0] S_INIT_WR = 3'd4;
  localparam logic [2:0] S_SWEEP   = 3'd5;
  localparam logic [2:0] S_RD      = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  // configuration registers
  logic [8:0]  gw_r, gw_nxt, gh_r, gh_nxt;
  logic [11:0] rad_r, rad_nxt;
  logic        cfg_wr;

  // sequencer registers
  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          clr_op_r, clr_op_nxt;
  logic          fr_r, fr_nxt;         // distance field valid
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic          dir_r, dir_nxt;       // 0 forward raster, 1 backward
  logic          chg_r, chg_nxt;       // some cell dropped in this pass
  logic          seed_r, seed_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [1:0]    pk_r, pk_nxt;         // kind of word arriving this cycle
  logic [DW-1:0] cur_r, cur_nxt;
  logic          occ_r, occ_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [DW-1:0] res_d_r, res_d_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [DW-1:0] out_dist_r, out_dist_nxt;

  // cell store port: {occupied, distance}
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  gdt_pkg::disk_ctl_t dk_ctl;
  logic [AW-1:0]      dk_addr;
  logic               dk_start;

  // grid size in use, clamped
  logic [UW-1:0] used_w;
  logic [VW-1:0] used_h;
  logic [XW-1:0] wl;
  logic [YW-1:0] hl;
  logic          in_inside;

  always_comb begin
    if (gw_r < 9'd2) begin
      used_w = UW'(2);
    end else if (int'(gw_r) > MAX_WIDTH) begin
      used_w = UW'(MAX_WIDTH);
    end else begin
      used_w = UW'(gw_r);
    end
    if (gh_r < 9'd2) begin
      used_h = VW'(2);
    end else if (int'(gh_r) > MAX_HEIGHT) begin
      used_h = VW'(MAX_HEIGHT);
    end else begin
      used_h = VW'(gh_r);
    end
  end

  assign wl        = XW'(used_w - UW'(1));
  assign hl        = YW'(used_h - VW'(1));
  assign in_inside = (int'(in_cell_x) < int'(used_w)) && (int'(in_cell_y) < int'(used_h));

  // neighbor walk around the current cell
  logic          x_lo, x_hi, y_lo, y_hi, first_cell, last_cell;
  logic [XW-1:0] xm, xp;
  logic [YW-1:0] ym, yp;
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;
  logic          nb_vld, nb_diag;
  logic [1:0]    nb_kind;

  assign x_lo       = x_r == '0;
  assign y_lo       = y_r == '0;
  assign x_hi       = x_r == wl;
  assign y_hi       = y_r == hl;
  assign xm         = x_r - XW'(1);
  assign xp         = x_r + XW'(1);
  assign ym         = y_r - YW'(1);
  assign yp         = y_r + YW'(1);
  assign first_cell = x_lo && y_lo;
  assign last_cell  = x_hi && y_hi;

  always_comb begin
    nb_x    = x_r;
    nb_y    = y_r;
    nb_vld  = 1'b1;
    nb_diag = 1'b0;
    case (step_r)
      3'd1: begin
        nb_x   = dir_r ? xp : xm;
        nb_vld = dir_r ? !x_hi : !x_lo;
      end
      3'd2: begin
        nb_y   = dir_r ? yp : ym;
        nb_vld = dir_r ? !y_hi : !y_lo;
      end
      3'd3: begin
        nb_x    = dir_r ? xp : xm;
        nb_y    = dir_r ? yp : ym;
        nb_vld  = dir_r ? (!x_hi && !y_hi) : (!x_lo && !y_lo);
        nb_diag = 1'b1;
      end
      3'd4: begin
        nb_x    = dir_r ? xm : xp;
        nb_y    = dir_r ? yp : ym;
        nb_vld  = dir_r ? (!x_lo && !y_hi) : (!x_hi && !y_lo);
        nb_diag = 1'b1;
      end
      default: begin
        nb_vld = step_r == 3'd0;
      end
    endcase
    if (!nb_vld) begin
      nb_kind = gdt_pkg::K_NONE;
    end else if (step_r == 3'd0) begin
      nb_kind = gdt_pkg::K_SELF;
    end else if (nb_diag) begin
      nb_kind = gdt_pkg::K_DIAG;
    end else begin
      nb_kind = gdt_pkg::K_ORTH;
    end
  end

  // relax the current cell against the word that just came back
  logic [DW-1:0] from_d;
  logic [DW:0]   cand;
  logic          is_nb, drop;
  logic [DW-1:0] cur_upd;

  assign from_d = mem_rdata[DW-1:0];
  assign is_nb  = (pk_r == gdt_pkg::K_ORTH) || (pk_r == gdt_pkg::K_DIAG);
  assign cand   = {1'b0, from_d}
                + ((pk_r == gdt_pkg::K_DIAG) ? gdt_pkg::COST_DIAG : gdt_pkg::COST_ORTHO);
  assign drop   = is_nb && (from_d != gdt_pkg::DIST_FAR) && (cand < {1'b0, cur_r});

  always_comb begin
    if (pk_r == gdt_pkg::K_SELF) begin
      cur_upd = from_d;
    end else if (drop) begin
      cur_upd = cand[DW-1:0];
    end else begin
      cur_upd = cur_r;
    end
  end

  assign in_ready  = st_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_status   = out_status_r;
  assign out_distance = out_dist_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      gdt_pkg::REG_WIDTH:  prdata = 32'(gw_r);
      gdt_pkg::REG_HEIGHT: prdata = 32'(gh_r);
      gdt_pkg::REG_RADIUS: prdata = 32'(rad_r);
      default:             prdata = '0;
    endcase
  end

  // main sequencer
  always_comb begin
    gw_nxt       = gw_r;
    gh_nxt       = gh_r;
    rad_nxt      = rad_r;
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    clr_op_nxt   = clr_op_r;
    fr_nxt       = fr_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    dir_nxt      = dir_r;
    chg_nxt      = chg_r;
    seed_nxt     = seed_r;
    step_nxt     = step_r;
    pk_nxt       = gdt_pkg::K_NONE;
    cur_nxt      = cur_r;
    occ_nxt      = occ_r;
    res_st_nxt   = res_st_r;
    res_d_nxt    = res_d_r;
    mem_we       = 1'b0;
    mem_waddr    = {y_r, x_r};
    mem_wdata    = '0;
    mem_raddr    = {y_r, x_r};
    dk_start     = 1'b0;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_dist_nxt   = out_dist_r;

    case (st_r)
      S_CLR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (&clr_addr_r) begin
          if (clr_op_r) begin
            res_st_nxt = gdt_pkg::ST_OK;
            res_d_nxt  = '0;
            st_nxt     = S_FIN;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_d_nxt = '0;
          case (in_operation)
            gdt_pkg::OP_CLEAR: begin
              fr_nxt       = 1'b0;
              clr_addr_nxt = '0;
              clr_op_nxt   = 1'b1;
              st_nxt       = S_CLR;
            end
            gdt_pkg::OP_MARK: begin
              if (!in_inside) begin
                res_st_nxt = gdt_pkg::ST_OUTSIDE;
                st_nxt     = S_FIN;
              end else begin
                dk_start = 1'b1;
                fr_nxt   = 1'b0;
                st_nxt   = S_MARK;
              end
            end
            gdt_pkg::OP_COMPUTE: begin
              x_nxt    = '0;
              y_nxt    = '0;
              seed_nxt = 1'b0;
              st_nxt   = S_INIT_RD;
            end
            default: begin
              if (!in_inside) begin
                res_st_nxt = gdt_pkg::ST_OUTSIDE;
                st_nxt     = S_FIN;
              end else if (!fr_r) begin
                res_st_nxt = gdt_pkg::ST_NOT_DONE;
                st_nxt     = S_FIN;
              end else begin
                mem_raddr = {YW'(in_cell_y), XW'(in_cell_x)};
                st_nxt    = S_RD;
              end
            end
          endcase
        end
      end
      S_MARK: begin
        mem_we    = dk_ctl.wr;
        mem_waddr = dk_addr;
        mem_wdata = {1'b1, {DW{1'b0}}};
        if (dk_ctl.done) begin
          res_st_nxt = gdt_pkg::ST_OK;
          st_nxt     = S_FIN;
        end
      end
      S_INIT_RD: begin
        st_nxt = S_INIT_WR;
      end
      S_INIT_WR: begin
        // occupied cells seed at zero, the rest start far away
        mem_we    = 1'b1;
        mem_wdata = {mem_rdata[DW], mem_rdata[DW] ? {DW{1'b0}} : gdt_pkg::DIST_FAR};
        seed_nxt  = seed_r || mem_rdata[DW];
        st_nxt    = S_INIT_RD;
        if (x_hi) begin
          x_nxt = '0;
          y_nxt = yp;
        end else begin
          x_nxt = xp;
        end
        if (last_cell) begin
          x_nxt = '0;
          y_nxt = '0;
          if (seed_r || mem_rdata[DW]) begin
            dir_nxt  = 1'b0;
            chg_nxt  = 1'b0;
            step_nxt = '0;
            st_nxt   = S_SWEEP;
          end else begin
            fr_nxt     = 1'b0;
            res_st_nxt = gdt_pkg::ST_NO_SEED;
            st_nxt     = S_FIN;
          end
        end
      end
      S_SWEEP: begin
        mem_raddr = {nb_y, nb_x};
        cur_nxt   = cur_upd;
        chg_nxt   = chg_r || drop;
        if (pk_r == gdt_pkg::K_SELF) begin
          occ_nxt = mem_rdata[DW];
        end
        if (step_r == LAST_STEP) begin
          mem_we    = 1'b1;
          mem_wdata = {occ_r, cur_upd};
          step_nxt  = '0;
          if (!dir_r) begin
            if (last_cell) begin
              dir_nxt = 1'b1;
            end else if (x_hi) begin
              x_nxt = '0;
              y_nxt = yp;
            end else begin
              x_nxt = xp;
            end
          end else begin
            if (first_cell) begin
              if (chg_r || drop) begin
                chg_nxt = 1'b0;
                dir_nxt = 1'b0;
              end else begin
                fr_nxt     = 1'b1;
                res_st_nxt = gdt_pkg::ST_OK;
                st_nxt     = S_FIN;
              end
            end else if (x_lo) begin
              x_nxt = wl;
              y_nxt = ym;
            end else begin
              x_nxt = xm;
            end
          end
        end else begin
          pk_nxt   = nb_kind;
          step_nxt = step_r + 3'd1;
        end
      end
      S_RD: begin
        res_st_nxt = gdt_pkg::ST_OK;
        res_d_nxt  = from_d;
        st_nxt     = S_FIN;
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          out_dist_nxt   = res_d_r;
          clr_op_nxt     = 1'b0;
          st_nxt         = S_IDLE;
        end
      end
    endcase

    if (cfg_wr) begin
      case (paddr[3:2])
        gdt_pkg::REG_WIDTH: begin
          gw_nxt = pwdata[8:0];
          fr_nxt = 1'b0;
        end
        gdt_pkg::REG_HEIGHT: begin
          gh_nxt = pwdata[8:0];
          fr_nxt = 1'b0;
        end
        gdt_pkg::REG_RADIUS: begin
          rad_nxt = pwdata[11:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r        <= 9'd256;
      gh_r        <= 9'd256;
      rad_r       <= '0;
      st_r        <= S_CLR;
      clr_addr_r  <= '0;
      clr_op_r    <= 1'b0;
      fr_r        <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      pk_r        <= gdt_pkg::K_NONE;
    end else begin
      gw_r        <= gw_nxt;
      gh_r        <= gh_nxt;
      rad_r       <= rad_nxt;
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_op_r    <= clr_op_nxt;
      fr_r        <= fr_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      pk_r        <= pk_nxt;
    end
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    dir_r        <= dir_nxt;
    chg_r        <= chg_nxt;
    seed_r       <= seed_nxt;
    cur_r        <= cur_nxt;
    occ_r        <= occ_nxt;
    res_st_r     <= res_st_nxt;
    res_d_r      <= res_d_nxt;
    out_status_r <= out_status_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  gdt_ram #(
    .WIDTH (WW),
    .DEPTH (2 ** AW)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gdt_disk #(
    .XW (XW),
    .YW (YW),
    .UW (UW),
    .VW (VW)
  ) u_disk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dk_start),
    .px     (in_cell_x),
    .py     (in_cell_y),
    .radius (rad_r),
    .used_w (used_w),
    .used_h (used_h),
    .ctl    (dk_ctl),
    .addr   (dk_addr)
  );

  // the store is only written by the clear sweep, the disk walk, init and sweeps
  `GDT_ASSERT_NOW(a_no_idle_write, (st_r == S_IDLE) || (st_r == S_FIN), !mem_we, "store written while idle")
  // the field only becomes valid at the end of a converged sweep pair
  `GDT_ASSERT_NEXT(a_ready_from_sweep, !fr_r && !(st_r == S_SWEEP && step_r == LAST_STEP), !fr_r, "field valid without compute")
  // sweep position never leaves the grid in use
  `GDT_ASSERT_NOW(a_sweep_in_grid, st_r == S_SWEEP, (x_r <= wl) && (y_r <= hl) && (step_r <= LAST_STEP), "sweep out of grid")

endmodule

>>> hdl/gdt_ram.sv
module gdt_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/gdt_disk.sv
module gdt_disk #(
  parameter int XW = 8,
  parameter int YW = 8,
  parameter int UW = 9,
  parameter int VW = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [7:0]          px,
  input  logic [7:0]          py,
  input  logic [11:0]         radius,
  input  logic [UW-1:0]       used_w,
  input  logic [VW-1:0]       used_h,
  output gdt_pkg::disk_ctl_t  ctl,
  output logic [XW+YW-1:0]    addr
);

  logic              busy_r, busy_nxt;
  logic [8:0]        k_r, k_nxt;
  logic signed [9:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [23:0]       rr_r, rr_nxt;
  logic [16:0]       dy2_r, dy2_nxt;
  logic [7:0]        px_r, px_nxt, py_r, py_nxt;

  logic [8:0]         k_start;
  logic signed [9:0]  ks, dy_inc;
  logic signed [19:0] dx_sq, dy_sq;
  logic [17:0]        sum_sq;
  logic               hit, in_x, in_y, row_end, last;
  logic signed [10:0] nx, ny;

  assign k_start = 9'((13'(radius) + 13'd15) >> 4);
  assign ks      = $signed({1'b0, k_r});
  assign dy_inc  = dy_r + 10'sd1;
  assign dx_sq   = dx_r * dx_r;
  assign dy_sq   = dy_inc * dy_inc;
  assign sum_sq  = 18'(dx_sq[16:0]) + 18'(dy2_r);
  assign hit     = {sum_sq, 8'd0} <= 26'(rr_r);

  // point cell held for the whole walk
  assign nx   = $signed({3'b000, px_r}) + {dx_r[9], dx_r};
  assign ny   = $signed({3'b000, py_r}) + {dy_r[9], dy_r};
  assign in_x = !nx[10] && (12'(nx[9:0]) < 12'(used_w));
  assign in_y = !ny[10] && (12'(ny[9:0]) < 12'(used_h));

  assign row_end = dx_r == ks;
  assign last    = row_end && (dy_r == ks);

  assign ctl.busy = busy_r;
  assign ctl.wr   = busy_r && in_x && in_y && hit;
  assign ctl.done = busy_r && last;
  assign addr     = {ny[YW-1:0], nx[XW-1:0]};

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    rr_nxt   = rr_r;
    dy2_nxt  = dy2_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = k_start;
      dx_nxt   = -$signed({1'b0, k_start});
      dy_nxt   = -$signed({1'b0, k_start});
      rr_nxt   = radius * radius;
      dy2_nxt  = 17'(k_start) * 17'(k_start);
      px_nxt   = px;
      py_nxt   = py;
    end else if (busy_r) begin
      if (row_end) begin
        dx_nxt = -ks;
        if (last) begin
          busy_nxt = 1'b0;
        end else begin
          dy_nxt  = dy_inc;
          dy2_nxt = dy_sq[16:0];
        end
      end else begin
        dx_nxt = dx_r + 10'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    k_r   <= k_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    rr_r  <= rr_nxt;
    dy2_r <= dy2_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
  end

endmodule

>>> bench/tb_grid_obstacle_distance_transform.sv
`timescale 1ns / 100ps

// expected result of one item
typedef struct {
  logic [1:0]  status;
  logic [16:0] distance;
} cell_reply_t;

// obstacle map model: keeps its own map, distance field and registers,
// and queues the reply each accepted item should produce
class distance_map_tracker;
  localparam int MAP_W = 256;
  localparam int MAP_H = 256;
  localparam int unsigned FAR_COST = 32'hFFFF_FFFF;

  bit          occ[MAP_W*MAP_H];
  int unsigned field[MAP_W*MAP_H];
  bit          field_valid;
  int unsigned width_reg, height_reg, radius_reg;
  cell_reply_t replies_due[$];
  int          mismatches;

  function new();
    foreach (occ[i]) occ[i] = 0;
    foreach (field[i]) field[i] = 0;
    field_valid = 0;
    width_reg = 256;
    height_reg = 256;
    radius_reg = 0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, int unsigned value);
    case (idx)
      gdt_pkg::REG_WIDTH: begin
        width_reg = value & 32'h1FF;
        field_valid = 0;
      end
      gdt_pkg::REG_HEIGHT: begin
        height_reg = value & 32'h1FF;
        field_valid = 0;
      end
      gdt_pkg::REG_RADIUS: radius_reg = value & 32'hFFF;
      default: ;
    endcase
  endfunction

  function int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // try to lower field[idx] through a neighbor
  function bit relax(int idx, int unsigned from, int unsigned cost);
    if (from == FAR_COST) return 0;
    if (from + cost < field[idx]) begin
      field[idx] = from + cost;
      return 1;
    end
    return 0;
  endfunction

  function void paint_disk(int px, int py, int w, int h);
    int r, k, nx, ny;
    r = radius_reg;
    k = (r + 15) >> 4;
    for (int dy = -k; dy <= k; dy++) begin
      for (int dx = -k; dx <= k; dx++) begin
        nx = px + dx;
        ny = py + dy;
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        if (k > 0 && 256 * (dx * dx + dy * dy) > r * r) continue;
        occ[ny * MAP_W + nx] = 1;
      end
    end
  endfunction

  // forward and backward raster sweeps until nothing drops
  function bit solve_field(int w, int h);
    bit seeded, changed;
    int i;
    seeded = 0;
    changed = 1;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        i = y * MAP_W + x;
        if (occ[i]) begin
          field[i] = 0;
          seeded = 1;
        end else begin
          field[i] = FAR_COST;
        end
      end
    end
    if (!seeded) return 0;
    while (changed) begin
      changed = 0;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          i = y * MAP_W + x;
          if (x > 0) changed |= relax(i, field[i-1], 256);
          if (y > 0) begin
            changed |= relax(i, field[i-MAP_W], 256);
            if (x > 0) changed |= relax(i, field[i-MAP_W-1], 362);
            if (x + 1 < w) changed |= relax(i, field[i-MAP_W+1], 362);
          end
        end
      end
      for (int y = h - 1; y >= 0; y--) begin
        for (int x = w - 1; x >= 0; x--) begin
          i = y * MAP_W + x;
          if (x + 1 < w) changed |= relax(i, field[i+1], 256);
          if (y + 1 < h) begin
            changed |= relax(i, field[i+MAP_W], 256);
            if (x + 1 < w) changed |= relax(i, field[i+MAP_W+1], 362);
            if (x > 0) changed |= relax(i, field[i+MAP_W-1], 362);
          end
        end
      end
    end
    return 1;
  endfunction

  function void note_item(logic [1:0] op, logic [7:0] cx, logic [7:0] cy);
    cell_reply_t rep;
    int w, h;
    bit in_grid;
    w = clamp_size(width_reg, MAP_W);
    h = clamp_size(height_reg, MAP_H);
    in_grid = (cx < w) && (cy < h);
    rep.status = gdt_pkg::ST_OK;
    rep.distance = '0;
    case (op)
      gdt_pkg::OP_CLEAR: begin
        foreach (occ[i]) occ[i] = 0;
        field_valid = 0;
      end
      gdt_pkg::OP_MARK: begin
        if (!in_grid) rep.status = gdt_pkg::ST_OUTSIDE;
        else begin
          paint_disk(cx, cy, w, h);
          field_valid = 0;
        end
      end
      gdt_pkg::OP_COMPUTE: begin
        field_valid = solve_field(w, h);
        if (!field_valid) rep.status = gdt_pkg::ST_NO_SEED;
      end
      default: begin
        if (!in_grid) rep.status = gdt_pkg::ST_OUTSIDE;
        else if (!field_valid) rep.status = gdt_pkg::ST_NOT_DONE;
        else rep.distance = field[cy * MAP_W + cx][16:0];
      end
    endcase
    replies_due.push_back(rep);
  endfunction

  function void check_reply(logic [1:0] status, logic [16:0] distance);
    cell_reply_t want;
    if (replies_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d distance %0d", status, distance);
      return;
    end
    want = replies_due.pop_front();
    if (status !== want.status || distance !== want.distance) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected status %0d distance %0d, got status %0d distance %0d",
                 want.status, want.distance, status, distance);
    end
  endfunction

  function int pending();
    return replies_due.size();
  endfunction
endclass

module tb_grid_obstacle_distance_transform;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_cell_x;
  logic [7:0]  in_cell_y;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [16:0] out_distance;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  distance_map_tracker map_model;
  int items_sent;
  int phase_idx;
  bit no_idle;     // phase with back-to-back traffic on both sides
  int grid_w, grid_h;

  grid_obstacle_distance_transform u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_distance(out_distance),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop; clears and the reset sweep cost a full store pass each
  initial begin
    #200_000_000;
    $display("** grid_obstacle_distance_transform: FAILED **");
    $finish;
  end

  // result side: random stall per item, checked on every accepted result
  initial begin
    int stall;
    out_ready = 0;
    stall = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        map_model.check_reply(out_status, out_distance);
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
      @(posedge clk);
    end
  end

  // one item on the input channel; valid stays up when there is no gap
  task automatic send_item(logic [1:0] op, logic [7:0] cx, logic [7:0] cy);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_cell_x <= cx;
    in_cell_y <= cy;
    do @(posedge clk); while (!(in_valid && in_ready));
    map_model.note_item(op, cx, cy);
    items_sent++;
  endtask

  // wait until every reply is back, then let the block settle
  task automatic drain();
    if (in_valid) begin
      in_valid <= 0;
      @(posedge clk);
    end
    while (map_model.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // setup then access cycle; the register takes the value on the access edge
  task automatic cfg_write(logic [1:0] idx, int unsigned value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    map_model.set_reg(idx, value);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned r);
    drain();
    cfg_write(gdt_pkg::REG_WIDTH, w);
    cfg_write(gdt_pkg::REG_HEIGHT, h);
    cfg_write(gdt_pkg::REG_RADIUS, r);
    grid_w = map_model.clamp_size(w, 256);
    grid_h = map_model.clamp_size(h, 256);
  endtask

  // mostly well-formed: marks, one compute, then a run of reads with occasional marks and computes
  task automatic random_phase();
    int n;
    int pick;
    if ($urandom_range(0, 9) == 0) set_grid($urandom_range(100, 256), 2, $urandom_range(0, 32));
    else set_grid($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(0, 48));
    // clears walk the whole store, so keep them rare
    if (phase_idx % 8 == 0) send_item(gdt_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
    n = $urandom_range(0, 4);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        send_item(gdt_pkg::OP_MARK, 8'($urandom), 8'($urandom));
      else
        send_item(gdt_pkg::OP_MARK, 8'($urandom_range(0, grid_w)),
                  8'($urandom_range(0, grid_h - 1)));
    end
    send_item(gdt_pkg::OP_COMPUTE, 8'($urandom), 8'($urandom));
    n = $urandom_range(15, 30);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 85)
        send_item(gdt_pkg::OP_READ, 8'($urandom_range(0, grid_w - 1)),
                  8'($urandom_range(0, grid_h - 1)));
      else if (pick < 92) send_item(gdt_pkg::OP_READ, 8'($urandom), 8'($urandom));
      else if (pick < 96)
        send_item(gdt_pkg::OP_MARK, 8'($urandom_range(0, grid_w - 1)),
                  8'($urandom_range(0, grid_h - 1)));
      else send_item(gdt_pkg::OP_COMPUTE, 8'($urandom), 8'($urandom));
    end
    phase_idx++;
  endtask

  initial begin
    map_model = new();
    items_sent = 0;
    phase_idx = 0;
    no_idle = 0;
    grid_w = 256;
    grid_h = 256;
    rst_n = 0;
    in_valid = 0;
    in_operation = gdt_pkg::OP_CLEAR;
    in_cell_x = 0;
    in_cell_y = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset map: nothing computed yet, and nothing to seed from
    send_item(gdt_pkg::OP_READ, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_COMPUTE, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd255, 8'd255);
    send_item(gdt_pkg::OP_MARK, 8'd255, 8'd255);

    // small grid: outside marks, one seed, corner reads
    set_grid(4, 3, 0);
    send_item(gdt_pkg::OP_MARK, 8'd4, 8'd0);
    send_item(gdt_pkg::OP_MARK, 8'd0, 8'd3);
    send_item(gdt_pkg::OP_MARK, 8'd3, 8'd2);
    send_item(gdt_pkg::OP_COMPUTE, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd3, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd0, 8'd2);
    send_item(gdt_pkg::OP_READ, 8'd255, 8'd255);
    send_item(gdt_pkg::OP_CLEAR, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd1, 8'd1);
    send_item(gdt_pkg::OP_COMPUTE, 8'd0, 8'd0);

    // size written below and above range gets clamped
    set_grid(511, 0, 20);
    send_item(gdt_pkg::OP_MARK, 8'd128, 8'd1);
    send_item(gdt_pkg::OP_COMPUTE, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd255, 8'd1);
    send_item(gdt_pkg::OP_READ, 8'd0, 8'd2);

    // widest window, clipped hard by a tiny grid
    set_grid(1, 3, 4095);
    send_item(gdt_pkg::OP_MARK, 8'd1, 8'd1);
    send_item(gdt_pkg::OP_COMPUTE, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd0, 8'd2);

    // tall thin grid
    set_grid(2, 256, 16);
    send_item(gdt_pkg::OP_MARK, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_COMPUTE, 8'd0, 8'd0);
    send_item(gdt_pkg::OP_READ, 8'd1, 8'd255);

    while (items_sent < 1850) begin
      no_idle = ($urandom_range(0, 5) == 0);
      random_phase();
    end
    no_idle = 0;

    drain();
    if (map_model.mismatches == 0)
      $display("** grid_obstacle_distance_transform: PASSED **");
    else
      $display("** grid_obstacle_distance_transform: FAILED **");
    $finish;
  end

endmodule
